// ----- design/assert_macros.svh -----
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/teia_pkg.sv -----
// Types and constants of the typed element-wise integer ALU.
package teia_pkg;

    localparam int DEFAULT_MAX_WIDTH = 32;
    localparam int DATA_W            = 32;
    localparam int TYPE_W            = 3;
    localparam int OP_W              = 3;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_TYPE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPERATION    = 1'd1;

    // element type codes
    localparam logic [TYPE_W-1:0] ET_INT32  = 3'd0;
    localparam logic [TYPE_W-1:0] ET_INT16  = 3'd1;
    localparam logic [TYPE_W-1:0] ET_INT8   = 3'd2;
    localparam logic [TYPE_W-1:0] ET_UINT32 = 3'd3;
    localparam logic [TYPE_W-1:0] ET_UINT16 = 3'd4;
    localparam logic [TYPE_W-1:0] ET_UINT8  = 3'd5;
    // spare type codes, they give a zero result
    localparam logic [TYPE_W-1:0] ET_SPARE_6 = 3'd6;
    localparam logic [TYPE_W-1:0] ET_SPARE_7 = 3'd7;

    // operation codes
    localparam logic [OP_W-1:0] OP_MUL = 3'd0;
    localparam logic [OP_W-1:0] OP_DIV = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD = 3'd2;
    localparam logic [OP_W-1:0] OP_SUB = 3'd3;
    localparam logic [OP_W-1:0] OP_MAX = 3'd4;
    localparam logic [OP_W-1:0] OP_MIN = 3'd5;
    localparam logic [OP_W-1:0] OP_POW = 3'd6;
    // spare operation code, gives a zero result
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_DIV   = 6'b000100,
        S_PSTEP = 6'b001000,
        S_PSAT  = 6'b010000,
        S_POST  = 6'b100000
    } state_t;

    // how the final result is formed from the working registers
    typedef enum logic [1:0] {
        POST_PASS = 2'd0,
        POST_MUL  = 2'd1,
        POST_DIV  = 2'd2,
        POST_POW  = 2'd3
    } post_t;

endpackage

// ----- design/typed_elementwise_int_alu.sv -----
// Top level of the typed element-wise integer ALU with its iterative shared unit.
//
// Usage: software writes element_type and operation on the cfg port while the
// block is idle. Each input beat (in_valid high, in_stall low) carries
// operand_a and operand_b; each output beat gives result_value and
// divide_by_zero. One input beat gives exactly one output beat.
// Add, sub, max, min, division by zero, unused codes and negative-exponent
// pow go from the accept straight to the final state; mul and div run on
// the bit-serial add/subtract unit doing one bit per cycle; pow runs
// square-and-multiply on that same unit, one saturating multiply at a time,
// and stops once the running power reaches 0, 1 or the cap, so at 32 bits
// it takes at most 10 multiplies, usually far fewer.
// One item is in flight at a time: in_stall stays high from the cycle after
// the accept until the result is loaded into the output register.
// The block therefore takes no new item until then.
// A stalled result holds in the output register; the sequencer waits in its
// final state until that register frees up.
// Reset clears both config registers to 0 (int32, mul) and empties the block.
module typed_elementwise_int_alu #(
    parameter int MAX_WIDTH = teia_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // config write port
    input  logic                               cfg_write,
    input  logic [teia_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [teia_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [teia_pkg::DATA_W-1:0]        operand_a,
    input  logic [teia_pkg::DATA_W-1:0]        operand_b,
    // output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [teia_pkg::DATA_W-1:0]        result_value,
    output logic                               divide_by_zero
);
    import teia_pkg::*;

    // datapath width: wide enough for the 16-bit types too
    localparam int DW    = (MAX_WIDTH > 16) ? MAX_WIDTH : 16;
    localparam int CNT_W = $clog2(DW);
    localparam logic [DW-1:0]    MASK_FULL = {DW{1'b1}} >> (DW - MAX_WIDTH);
    localparam logic [DW-1:0]    MASK_16   = DW'(32'h0000_FFFF);
    localparam logic [DW-1:0]    MASK_8    = DW'(32'h0000_00FF);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(DW - 1);

    // control registers
    state_t             state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    logic [TYPE_W-1:0]  element_type_reg, element_type_next;
    logic [OP_W-1:0]    operation_reg, operation_next;

    // payload registers
    logic [DW-1:0]      hi_reg, hi_next;
    logic [DW-1:0]      lo_reg, lo_next;
    logic [DW-1:0]      x_reg, x_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DW-1:0]      acc_reg, acc_next;
    logic [DW-1:0]      p_reg, p_next;
    logic [DW-1:0]      e_reg, e_next;
    logic [DW-1:0]      cap_reg, cap_next;
    logic [DW-1:0]      mask_reg, mask_next;
    logic               sgn_reg, sgn_next;
    logic               neg_reg, neg_next;
    logic               tgt_acc_reg, tgt_acc_next;
    post_t              post_reg, post_next;
    logic [DW-1:0]      res_reg, res_next;
    logic               dz_reg, dz_next;
    logic [DW-1:0]      out_res_reg, out_res_next;
    logic               out_dz_reg, out_dz_next;

    // operand decode
    logic [DW+DATA_W-1:0] a_wide, b_wide;
    logic [DW-1:0]      a_ext, b_ext;
    logic [DW-1:0]      mask, sbit, a, b, ma, mb, cap, ka, kb;
    logic               sgn, type_ok, na, nb;
    logic [DW-1:0]      simple_res, pow_neg_res;

    // shared add/subtract unit
    logic [DW:0]        alu_lhs, alu_rhs;
    logic               alu_sub;
    logic [DW+1:0]      alu_sum;

    // result forming
    logic [DW-1:0]      post_res, mul_sat;
    logic               post_dz, p_fixed;
    logic [DW+DATA_W-1:0] res_wide;

    logic               in_fire, out_free;

    assign a_wide = {{DW{1'b0}}, operand_a};
    assign b_wide = {{DW{1'b0}}, operand_b};
    assign a_ext  = a_wide[DW-1:0];
    assign b_ext  = b_wide[DW-1:0];

    always_comb
    begin
        mask    = MASK_FULL;
        sgn     = 1'b0;
        type_ok = 1'b1;
        case (element_type_reg)
            ET_INT32:  begin mask = MASK_FULL; sgn = 1'b1; end
            ET_INT16:  begin mask = MASK_16;   sgn = 1'b1; end
            ET_INT8:   begin mask = MASK_8;    sgn = 1'b1; end
            ET_UINT32: mask = MASK_FULL;
            ET_UINT16: mask = MASK_16;
            ET_UINT8:  mask = MASK_8;
            default:   type_ok = 1'b0;
        endcase
    end

    assign sbit = mask ^ (mask >> 1);
    assign a    = a_ext & mask;
    assign b    = b_ext & mask;
    assign na   = sgn && ((a & sbit) != '0);
    assign nb   = sgn && ((b & sbit) != '0);
    assign ma   = na ? ((~a + DW'(1)) & mask) : a;
    assign mb   = nb ? ((~b + DW'(1)) & mask) : b;
    assign cap  = sgn ? sbit : mask;
    // signed order = unsigned order with the sign bit flipped
    assign ka   = sgn ? (a ^ sbit) : a;
    assign kb   = sgn ? (b ^ sbit) : b;

    // negative exponent: only bases 0, 1 and -1 give a nonzero result
    always_comb
    begin
        if (a == '0)
            pow_neg_res = sbit - DW'(1);
        else if (a == DW'(1))
            pow_neg_res = DW'(1);
        else if (a == mask)
            pow_neg_res = b[0] ? mask : DW'(1);
        else
            pow_neg_res = '0;
    end

    always_comb
    begin
        case (operation_reg)
            OP_ADD:  simple_res = (a + b) & mask;
            OP_SUB:  simple_res = (a - b) & mask;
            OP_MAX:  simple_res = (ka > kb) ? a : b;
            OP_MIN:  simple_res = (ka > kb) ? b : a;
            OP_POW:  simple_res = pow_neg_res;
            default: simple_res = '0;
        endcase
    end

    // shared unit: add for shift-add multiply, subtract for restoring divide
    always_comb
    begin
        if (state_reg == S_DIV)
        begin
            alu_lhs = {hi_reg, lo_reg[DW-1]};
            alu_rhs = {1'b0, x_reg};
            alu_sub = 1'b1;
        end
        else
        begin
            alu_lhs = {1'b0, hi_reg};
            alu_rhs = lo_reg[0] ? {1'b0, x_reg} : '0;
            alu_sub = 1'b0;
        end
    end

    assign alu_sum = {1'b0, alu_lhs} + {1'b0, (alu_sub ? ~alu_rhs : alu_rhs)}
                   + (DW+2)'(alu_sub);

    // saturated product against the pow cap
    assign mul_sat = ((hi_reg != '0) || (lo_reg > cap_reg)) ? cap_reg : lo_reg;
    // 0, 1 and the cap square to themselves
    assign p_fixed = (p_reg == '0) || (p_reg == DW'(1)) || (p_reg == cap_reg);

    always_comb
    begin
        post_dz = 1'b0;
        case (post_reg)
            POST_PASS:
            begin
                post_res = res_reg;
                post_dz  = dz_reg;
            end
            POST_MUL: post_res = lo_reg & mask_reg;
            POST_DIV: post_res = (neg_reg ? (~lo_reg + DW'(1)) : lo_reg) & mask_reg;
            POST_POW:
            begin
                if (!sgn_reg)
                    post_res = acc_reg;
                else if (neg_reg)
                    post_res = (acc_reg >= cap_reg) ? cap_reg
                             : ((~acc_reg + DW'(1)) & mask_reg);
                else
                    post_res = (acc_reg >= cap_reg) ? (cap_reg - DW'(1)) : acc_reg;
            end
            default: post_res = '0;
        endcase
    end

    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next        = state_reg;
        out_valid_next    = out_valid_reg;
        element_type_next = element_type_reg;
        operation_next    = operation_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        x_next       = x_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        p_next       = p_reg;
        e_next       = e_reg;
        cap_next     = cap_reg;
        mask_next    = mask_reg;
        sgn_next     = sgn_reg;
        neg_next     = neg_reg;
        tgt_acc_next = tgt_acc_reg;
        post_next    = post_reg;
        res_next     = res_reg;
        dz_next      = dz_reg;
        out_res_next = out_res_reg;
        out_dz_next  = out_dz_reg;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_ELEMENT_TYPE: element_type_next = cfg_data;
                REG_OPERATION:    operation_next    = cfg_data;
                default:          ;
            endcase
        end

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    mask_next = mask;
                    sgn_next  = sgn;
                    cap_next  = cap;
                    hi_next   = '0;
                    cnt_next  = CNT_LAST;
                    post_next = POST_PASS;
                    res_next  = '0;
                    dz_next   = 1'b0;
                    state_next = S_POST;
                    if (!type_ok || operation_reg > OP_POW)
                        res_next = '0;
                    else if (operation_reg == OP_MUL)
                    begin
                        lo_next    = a;
                        x_next     = b;
                        post_next  = POST_MUL;
                        state_next = S_MUL;
                    end
                    else if (operation_reg == OP_DIV)
                    begin
                        if (b == '0)
                            dz_next = 1'b1;
                        else
                        begin
                            lo_next    = ma;
                            x_next     = mb;
                            neg_next   = na ^ nb;
                            post_next  = POST_DIV;
                            state_next = S_DIV;
                        end
                    end
                    else if (operation_reg == OP_POW && !nb)
                    begin
                        acc_next   = DW'(1);
                        p_next     = ma;
                        e_next     = b;
                        neg_next   = na && b[0];
                        post_next  = POST_POW;
                        state_next = S_PSTEP;
                    end
                    else
                        res_next = simple_res;
                end
            end

            S_MUL:
            begin
                hi_next  = alu_sum[DW:1];
                lo_next  = {alu_sum[0], lo_reg[DW-1:1]};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = (post_reg == POST_POW) ? S_PSAT : S_POST;
            end

            S_DIV:
            begin
                hi_next  = alu_sum[DW+1] ? alu_sum[DW-1:0] : alu_lhs[DW-1:0];
                lo_next  = {lo_reg[DW-2:0], alu_sum[DW+1]};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = S_POST;
            end

            S_PSTEP:
            begin
                hi_next  = '0;
                cnt_next = CNT_LAST;
                if (e_reg == '0)
                    state_next = S_POST;
                else if (p_fixed)
                begin
                    // remaining set exponent bits multiply by p each time
                    acc_next   = (p_reg == DW'(1)) ? acc_reg : p_reg;
                    state_next = S_POST;
                end
                else if (e_reg[0])
                begin
                    lo_next      = acc_reg;
                    x_next       = p_reg;
                    tgt_acc_next = 1'b1;
                    e_next       = {e_reg[DW-1:1], 1'b0};
                    state_next   = S_MUL;
                end
                else
                begin
                    lo_next      = p_reg;
                    x_next       = p_reg;
                    tgt_acc_next = 1'b0;
                    e_next       = e_reg >> 1;
                    state_next   = S_MUL;
                end
            end

            S_PSAT:
            begin
                if (tgt_acc_reg)
                    acc_next = mul_sat;
                else
                    p_next = mul_sat;
                state_next = S_PSTEP;
            end

            S_POST:
            begin
                if (out_free)
                begin
                    out_res_next   = post_res;
                    out_dz_next    = post_dz;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            element_type_reg <= ET_INT32;
            operation_reg    <= OP_MUL;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            element_type_reg <= element_type_next;
            operation_reg    <= operation_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        x_reg       <= x_next;
        cnt_reg     <= cnt_next;
        acc_reg     <= acc_next;
        p_reg       <= p_next;
        e_reg       <= e_next;
        cap_reg     <= cap_next;
        mask_reg    <= mask_next;
        sgn_reg     <= sgn_next;
        neg_reg     <= neg_next;
        tgt_acc_reg <= tgt_acc_next;
        post_reg    <= post_next;
        res_reg     <= res_next;
        dz_reg      <= dz_next;
        out_res_reg <= out_res_next;
        out_dz_reg  <= out_dz_next;
    end

    assign res_wide       = {{DATA_W{1'b0}}, out_res_reg};
    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign result_value   = res_wide[DATA_W-1:0];
    assign divide_by_zero = out_dz_reg;

endmodule

// ----- design/teia_checker.sv -----
// Port-level checker for the typed element-wise integer ALU, with its bind.
`include "assert_macros.svh"

module teia_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [teia_pkg::DATA_W-1:0] result_value,
    input logic                        divide_by_zero
);
    import teia_pkg::*;

    // a stalled output beat holds
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_value) && $stable(divide_by_zero))
    // divide by zero always reports a zero result
    `ASSERT_IMPLIES(a_dz_zero, out_valid && divide_by_zero, result_value == '0)
    // one item at a time: busy right after an accept
    `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // a new result only comes out of a busy cycle
    `ASSERT_IMPLIES(a_result_from_work, $rose(out_valid), $past(in_stall))

endmodule

bind typed_elementwise_int_alu teia_checker u_teia_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_value   (result_value),
    .divide_by_zero (divide_by_zero)
);

// ----- tb/teia_result_checker.sv -----
// Checker for the typed element-wise integer ALU: mirrors config, predicts and compares beats.
module teia_result_checker #(
    parameter int MAX_WIDTH = teia_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [teia_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [teia_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [teia_pkg::DATA_W-1:0]     operand_a,
    input  logic [teia_pkg::DATA_W-1:0]     operand_b,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [teia_pkg::DATA_W-1:0]     result_value,
    input  logic                            divide_by_zero,
    output int                              pending_results,
    output int                              mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import teia_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              dz;
        logic [TYPE_W-1:0] etype;
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } alu_outcome_t;

    logic [TYPE_W-1:0] elem_type;
    logic [OP_W-1:0]   alu_op;
    alu_outcome_t      awaited_outcomes[$];

    function automatic logic [63:0] capped_product(logic [63:0] x, logic [63:0] y,
                                                   logic [63:0] cap);
        if (x == 0 || y == 0)
            return 64'd0;
        if (x > cap / y)
            return cap;
        return (x * y > cap) ? cap : x * y;
    endfunction

    // magnitude of base**e, clipped at cap
    function automatic logic [63:0] capped_power(logic [63:0] base, logic [63:0] e,
                                                 logic [63:0] cap);
        logic [63:0] acc;
        logic [63:0] p;
        acc = 64'd1;
        p   = (base > cap) ? cap : base;
        while (e != 0)
        begin
            if (e[0])
                acc = capped_product(acc, p, cap);
            p = capped_product(p, p, cap);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic alu_outcome_t compute_alu(logic [TYPE_W-1:0] et, logic [OP_W-1:0] op,
                                                 logic [DATA_W-1:0] a_in,
                                                 logic [DATA_W-1:0] b_in);
        int           w;
        bit           sgn;
        bit           na;
        bit           nb;
        bit           neg;
        logic [63:0]  m;
        logic [63:0]  sbit;
        logic [63:0]  a;
        logic [63:0]  b;
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [63:0]  ka;
        logic [63:0]  kb;
        logic [63:0]  mag;
        logic [63:0]  r;
        alu_outcome_t res;
        res       = '0;
        res.etype = et;
        res.op    = op;
        res.a     = a_in;
        res.b     = b_in;
        r         = 64'd0;
        case (et)
            ET_INT32:  begin w = MAX_WIDTH; sgn = 1'b1; end
            ET_INT16:  begin w = 16;        sgn = 1'b1; end
            ET_INT8:   begin w = 8;         sgn = 1'b1; end
            ET_UINT32: begin w = MAX_WIDTH; sgn = 1'b0; end
            ET_UINT16: begin w = 16;        sgn = 1'b0; end
            ET_UINT8:  begin w = 8;         sgn = 1'b0; end
            default:   return res;
        endcase
        m    = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        sbit = 64'd1 << (w - 1);
        a    = {32'd0, a_in} & m;
        b    = {32'd0, b_in} & m;
        na   = sgn && ((a & sbit) != 0);
        nb   = sgn && ((b & sbit) != 0);
        ma   = na ? ((~a + 64'd1) & m) : a;
        mb   = nb ? ((~b + 64'd1) & m) : b;
        case (op)
            OP_MUL: r = a * b;
            OP_DIV:
            begin
                if (b == 0)
                    res.dz = 1'b1;
                else
                begin
                    r = ma / mb;
                    if (na != nb)
                        r = ~r + 64'd1;
                end
            end
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MAX, OP_MIN:
            begin
                // offset binary makes the signed compare an unsigned one
                ka = sgn ? (a ^ sbit) : a;
                kb = sgn ? (b ^ sbit) : b;
                if (op == OP_MAX)
                    r = (ka > kb) ? a : b;
                else
                    r = (ka > kb) ? b : a;
            end
            OP_POW:
            begin
                if (!sgn)
                    r = capped_power(a, b, m);
                else if (nb)
                begin
                    if (a == 0)
                        r = sbit - 64'd1;
                    else if (a == 1)
                        r = 64'd1;
                    else if (a == m)
                        r = b[0] ? m : 64'd1;
                    else
                        r = 64'd0;
                end
                else
                begin
                    mag = capped_power(ma, b, sbit);
                    neg = na && b[0];
                    if (neg)
                        r = (mag >= sbit) ? sbit : (~mag + 64'd1);
                    else
                        r = (mag >= sbit) ? sbit - 64'd1 : mag;
                end
            end
            default: r = 64'd0;
        endcase
        res.value = r[DATA_W-1:0] & m[DATA_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alu_outcome_t exp_o;
        if (!rst_n)
        begin
            elem_type       = ET_INT32;
            alu_op          = OP_MUL;
            pending_results = 0;
            mismatch_count  = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_ELEMENT_TYPE: elem_type = cfg_data;
                    REG_OPERATION:    alu_op    = cfg_data;
                    default:          ;
                endcase
            end
            // output side first so a same-edge input beat cannot match itself
            if (out_valid && !out_stall)
            begin
                if (awaited_outcomes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result beat %h dz %0d",
                                 $realtime, result_value, divide_by_zero);
                end
                else
                begin
                    exp_o = awaited_outcomes.pop_front();
                    if (result_value !== exp_o.value || divide_by_zero !== exp_o.dz)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: mismatch type %0d op %0d a %h b %h: ",
                                      "expected %h dz %0d, got %h dz %0d"},
                                     $realtime, exp_o.etype, exp_o.op, exp_o.a, exp_o.b,
                                     exp_o.value, exp_o.dz, result_value, divide_by_zero);
                    end
                end
            end
            if (in_valid && !in_stall)
                awaited_outcomes.push_back(compute_alu(elem_type, alu_op, operand_a, operand_b));
            pending_results = awaited_outcomes.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the typed element-wise integer ALU: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import teia_pkg::*;

    // Slowest legal item is a long pow (10 multiplies) plus a full sender
    // gap and receiver stall; for ~900 items this leaves a wide margin.
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int RANDOM_ITEMS = 850;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [DATA_W-1:0]     operand_a;
    logic [DATA_W-1:0]     operand_b;
    logic                  out_valid;
    logic                  out_stall;
    logic [DATA_W-1:0]     result_value;
    logic                  divide_by_zero;

    int pending_results;
    int mismatch_count;
    int cycle_count = 0;

    // idle knobs, changed per phase; zero gives a stretch with no idling
    int gap_max;
    int stall_max;

    // shadow of what the block holds in its config registers
    logic [TYPE_W-1:0] cur_type;
    logic [OP_W-1:0]   cur_op;

    typed_elementwise_int_alu i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operand_a      (operand_a),
        .operand_b      (operand_b),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_value   (result_value),
        .divide_by_zero (divide_by_zero)
    );

    teia_result_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operand_a       (operand_a),
        .operand_b       (operand_b),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_value    (result_value),
        .divide_by_zero  (divide_by_zero),
        .pending_results (pending_results),
        .mismatch_count  (mismatch_count)
    );

    always #4 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("typed_elementwise_int_alu verification failed");
            $finish;
        end
    end

    // Receiver: one random stall per result beat, applied at the falling edge,
    // then stall stays low until the next result beat is taken.
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = $urandom_range(0, stall_max);
            if (n > 0)
            begin
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall = 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Lowers valid and waits until every predicted beat has come back. All
    // items give a result, so the block is idle then. Called at a falling
    // edge.
    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // Config only changes with the block idle.
    task automatic set_config(logic [TYPE_W-1:0] et, logic [OP_W-1:0] op);
        if (et != cur_type || op != cur_op)
        begin
            wait_drained();
            if (et != cur_type)
                write_cfg(REG_ELEMENT_TYPE, et);
            if (op != cur_op)
                write_cfg(REG_OPERATION, op);
            cur_type = et;
            cur_op   = op;
        end
    endtask

    // One input beat. Entered at a falling edge; returns at the falling edge
    // after the accept with valid still high, so a back-to-back beat just
    // swaps the payload in that same step.
    task automatic send_beat(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        operand_a = a;
        operand_b = b;
        in_valid  = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic directed_beat(logic [TYPE_W-1:0] et, logic [OP_W-1:0] op,
                                 logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        set_config(et, op);
        send_beat(a, b);
    endtask

    function automatic int type_width(logic [TYPE_W-1:0] et);
        case (et)
            ET_INT16, ET_UINT16: return 16;
            ET_INT8, ET_UINT8:   return 8;
            default:             return 32;
        endcase
    endfunction

    // Operand mix: raw random patterns, small signed values, and the edges of
    // the type (zero, one, two, all ones, sign bit, largest positive). Exponents
    // lean small so pow does not always saturate at once. Bits above the type
    // width often carry junk that the block must ignore.
    function automatic logic [DATA_W-1:0] draw_operand(logic [TYPE_W-1:0] et, bit exponent);
        int                w;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] sbit;
        logic [DATA_W-1:0] v;
        int                pick;
        w    = type_width(et);
        mask = (w >= 32) ? '1 : ((32'd1 << w) - 32'd1);
        sbit = 32'd1 << (w - 1);
        pick = $urandom_range(0, 9);
        if (exponent && pick <= 5)
            v = $urandom_range(0, 40);
        else if (pick <= 3)
            v = $urandom;
        else if (pick <= 6)
            v = $urandom_range(0, 16) - 8;
        else
        begin
            case ($urandom_range(0, 5))
                0:       v = 32'd0;
                1:       v = 32'd1;
                2:       v = mask;
                3:       v = sbit;
                4:       v = sbit - 32'd1;
                default: v = 32'd2;
            endcase
        end
        if ($urandom_range(0, 1) == 1)
            v = (v & mask) | ($urandom & ~mask);
        return v;
    endfunction

    initial
    begin
        int               phase_len;
        int               drain_at;
        int               sent;
        bit               first_phase;
        logic [TYPE_W-1:0] et;
        logic [OP_W-1:0]   op;

        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        operand_a   = '0;
        operand_b   = '0;
        gap_max     = 3;
        stall_max   = 3;
        cur_type    = ET_INT32;
        cur_op      = OP_MUL;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- directed: field extremes, every op, every special case ----
        directed_beat(ET_INT32, OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        directed_beat(ET_INT32, OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF); // min / -1 wraps
        directed_beat(ET_INT32, OP_DIV, 32'h0000_0005, 32'h0000_0000); // divide by zero
        directed_beat(ET_INT32, OP_DIV, 32'hFFFF_FFF9, 32'h0000_0002); // truncates to -3
        directed_beat(ET_INT32, OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
        directed_beat(ET_INT32, OP_SUB, 32'h0000_0000, 32'h0000_0001);
        directed_beat(ET_INT32, OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
        directed_beat(ET_INT32, OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
        directed_beat(ET_INT32, OP_POW, 32'h0000_0003, 32'h0000_0028); // positive overflow
        directed_beat(ET_INT32, OP_POW, 32'hFFFF_FFFD, 32'h0000_0029); // negative overflow
        directed_beat(ET_INT32, OP_POW, 32'h0000_0000, 32'h0000_0000); // zero to the zero
        directed_beat(ET_INT32, OP_POW, 32'h0000_0000, 32'hFFFF_FFFF); // zero, negative exp
        directed_beat(ET_INT32, OP_POW, 32'h0000_0001, 32'hFFFF_FFFE); // one, negative exp
        directed_beat(ET_INT32, OP_POW, 32'hFFFF_FFFF, 32'hFFFF_FFFD); // -1, odd negative
        directed_beat(ET_INT32, OP_POW, 32'hFFFF_FFFF, 32'hFFFF_FFFE); // -1, even negative
        directed_beat(ET_INT32, OP_POW, 32'h0000_0005, 32'hFFFF_FFFF); // other base, neg
        directed_beat(ET_INT32, OP_POW, 32'h0000_0002, 32'h7FFF_FFFF);
        directed_beat(ET_INT8,  OP_POW, 32'h0000_00FE, 32'h0000_0007); // exactly -128
        directed_beat(ET_INT16, OP_DIV, 32'hABCD_8000, 32'h1234_FFFF); // junk high bits
        directed_beat(ET_UINT8, OP_POW, 32'h0000_0002, 32'h0000_0008); // saturates to 255
        directed_beat(ET_UINT32, OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        directed_beat(ET_UINT32, OP_DIV, 32'hFFFF_FFFF, 32'h0000_0000);
        directed_beat(ET_UINT16, OP_MAX, 32'h0000_FFFF, 32'h0000_0001);
        directed_beat(ET_SPARE_6, OP_ADD, 32'h0000_0001, 32'h0000_0002); // unused type
        directed_beat(ET_INT32, OP_SPARE_7, 32'h0000_0001, 32'h0000_0002); // unused op

        // ---- random phases, one config each ----
        sent        = 0;
        first_phase = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            et = ($urandom_range(0, 19) == 0)
                 ? TYPE_W'($urandom_range(ET_SPARE_6, ET_SPARE_7))
                 : TYPE_W'($urandom_range(ET_INT32, ET_UINT8));
            op = ($urandom_range(0, 15) == 0)
                 ? OP_SPARE_7 : OP_W'($urandom_range(OP_MUL, OP_POW));
            phase_len = $urandom_range(10, 50);
            // at least one mid-phase pause until the block has gone empty
            drain_at  = (first_phase || $urandom_range(0, 3) == 0)
                        ? $urandom_range(0, phase_len - 1) : -1;
            first_phase = 1'b0;
            gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 9;
            stall_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
            set_config(et, op);
            for (int i = 0; i < phase_len; i++)
            begin
                if (i == drain_at)
                    wait_drained();
                send_beat(draw_operand(et, 1'b0), draw_operand(et, op == OP_POW));
            end
            sent += phase_len;
        end

        // ---- drain and give late or stray beats time to show ----
        wait_drained();
        repeat (40) @(negedge clk);

        if (mismatch_count == 0 && pending_results == 0)
            $display("typed_elementwise_int_alu verification clean");
        else
            $display("typed_elementwise_int_alu verification failed");
        $finish;
    end

endmodule
